@@ design/assert_macros.svh @@
// Assertion macros used by the RTL of the water cell contour polygonizer.
// Needs nothing else; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The expression must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ design/wccp_pkg.sv @@
// Package of the water cell contour polygonizer: widths, vertex descriptor
// types and the function that maps a wet-corner mask to its vertex list. No dependencies.
`default_nettype none

package wccp_pkg;

  localparam int SIDE_CELLS = 256;
  localparam int MAX_VTX    = 6;
  localparam int CNT_W      = 3;
  localparam int COORD_W    = 26;
  localparam int Z_W        = 33;
  localparam logic signed [31:0] NO_WATER = 32'sh8000_0000;

  // One vertex: offsets in half cells from the cell's own corner, the corner
  // whose water height it carries, and whether it closes a polygon.
  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] zsel;
    logic       poly_end;
  } vtx_t;

  typedef struct packed {
    vtx_t [MAX_VTX-1:0] v;
    logic [CNT_W-1:0]   n;
  } vlist_t;

  // Corners are numbered 0:(0,0) 1:(1,0) 2:(1,1) 3:(0,1).
  function automatic logic ofs_x(logic [1:0] c);
    return c[0] ^ c[1];
  endfunction

  function automatic logic ofs_y(logic [1:0] c);
    return c[1];
  endfunction

  function automatic vtx_t corner_vtx(logic [1:0] c);
    vtx_t r;
    r.dx       = {ofs_x(c), 1'b0};
    r.dy       = {ofs_y(c), 1'b0};
    r.zsel     = c;
    r.poly_end = 1'b0;
    return r;
  endfunction

  function automatic vtx_t mid_vtx(logic [1:0] a, logic [1:0] b);
    vtx_t r;
    r.dx       = 2'(ofs_x(a)) + 2'(ofs_x(b));
    r.dy       = 2'(ofs_y(a)) + 2'(ofs_y(b));
    r.zsel     = a;
    r.poly_end = 1'b0;
    return r;
  endfunction

  // Marching squares over one cell: all corners wet give the square; else each run of
  // wet corners becomes a fan polygon opened and closed by its boundary edge midpoints.
  function automatic vlist_t build_list(logic [3:0] wet);
    vlist_t     r;
    int         n;
    logic [1:0] c;
    logic [1:0] nx;
    logic [1:0] prev;
    logic       stop;
    r = '0;
    n = 0;
    if (wet == 4'hF) begin
      for (int i = 0; i < 4; i++) begin
        r.v[i] = corner_vtx(2'(i));
      end
      r.v[3].poly_end = 1'b1;
      n = 4;
    end else begin
      for (int s = 0; s < 4; s++) begin
        prev = 2'(s + 3);
        if (wet[s] && !wet[prev]) begin
          if (n < MAX_VTX) r.v[n] = mid_vtx(2'(s), prev);
          n++;
          c    = 2'(s);
          stop = 1'b0;
          for (int run = 0; run < 4; run++) begin
            if (!stop && wet[c]) begin
              if (n < MAX_VTX) r.v[n] = corner_vtx(c);
              n++;
              nx = c + 2'd1;
              if (!wet[nx]) begin
                if (n < MAX_VTX) begin
                  r.v[n]          = mid_vtx(c, nx);
                  r.v[n].poly_end = 1'b1;
                end
                n++;
                stop = 1'b1;
              end
              c = nx;
            end else begin
              stop = 1'b1;
            end
          end
        end
      end
    end
    r.n = CNT_W'(n);
    return r;
  endfunction

  // Number of vertices that a wet-corner mask gives.
  function automatic logic [CNT_W-1:0] vtx_count(logic [3:0] wet);
    vlist_t r;
    r = build_list(wet);
    return r.n;
  endfunction

endpackage

`default_nettype wire

@@ design/water_cell_contour_polygonizer_top.sv @@
// Water cell contour polygonizer, top level: a four-stage pipeline from cell
// request to vertex stream. Depends on wccp_pkg and assert_macros.svh.
//
// Each accepted cell request is turned into zero to six vertices, one per
// cycle while the output is not stalled, in fan order. A cell that gives
// vertices holds the vertex sequencer until its last vertex leaves it; the
// worst case is six (two diagonal triangles), and a fully wet cell gives four.
// Cells that give no vertices (all dry, or outside the tile) are dropped in
// the second stage without touching the sequencer. Stage one registers the
// request, stage two decides which corners are wet and forms the heights
// plus one, stage three steps through the vertex list of the wet mask and
// scales the grid position by cell_step with one 10x16 multiplier per axis,
// and stage four is the output register. A new cell request is taken while
// earlier cells are still in flight and while a finished vertex waits at the
// output. Coordinates leave in half units. cell_step resets to 1 and is to
// be written only while the block is idle; a step of zero is legal and makes
// every coordinate zero.
`default_nettype none

`include "assert_macros.svh"

module water_cell_contour_polygonizer_top
  import wccp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_cell_step_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [7:0]           cell_x_i,
  input  wire logic [7:0]           cell_y_i,
  input  wire logic signed [31:0]   water_z_00_i,
  input  wire logic signed [31:0]   water_z_10_i,
  input  wire logic signed [31:0]   water_z_11_i,
  input  wire logic signed [31:0]   water_z_01_i,
  input  wire logic signed [31:0]   ground_z_00_i,
  input  wire logic signed [31:0]   ground_z_10_i,
  input  wire logic signed [31:0]   ground_z_11_i,
  input  wire logic signed [31:0]   ground_z_01_i,
  input  wire logic [3:0]           kind_mask_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [COORD_W-1:0]   vertex_x2_o,
  output      logic [COORD_W-1:0]   vertex_y2_o,
  output      logic signed [Z_W-1:0] vertex_z_o,
  output      logic                 polygon_end_o,
  output      logic                 last_o
);

  // The configured grid spacing.
  logic [15:0] cell_step_q;

  // Stage one: the registered cell request.
  logic                     s1_v_q;
  logic [7:0]               s1_cx_q, s1_cy_q;
  logic signed [31:0]       s1_wz_q [4];
  logic signed [31:0]       s1_gz_q [4];
  logic [3:0]               s1_kind_q;

  // Stage two: wet mask and the heights plus one.
  logic                     s2_v_q;
  logic [3:0]               s2_mask_q, s2_mask_d;
  logic [7:0]               s2_cx_q, s2_cy_q;
  logic signed [Z_W-1:0]    s2_z_q [4];
  logic [CNT_W-1:0]         s2_n;

  // Stage three: the vertex sequencer.
  logic                     seq_v_q;
  logic [3:0]               seq_mask_q;
  logic [7:0]               seq_cx_q, seq_cy_q;
  logic signed [Z_W-1:0]    seq_z_q [4];
  logic [CNT_W-1:0]         seq_k_q, seq_n_q;
  vlist_t                   seq_list;
  vtx_t                     seq_vtx;
  logic                     seq_last;
  logic [9:0]               seq_xs, seq_ys;
  logic [COORD_W-1:0]       seq_x2, seq_y2;

  // Stage four: the output register.
  logic                     out_v_q;
  logic [COORD_W-1:0]       out_x2_q, out_y2_q;
  logic signed [Z_W-1:0]    out_z_q;
  logic                     out_pend_q, out_last_q;

  logic out_ready, emit, seq_ready, s2_ready, s1_ready, seq_load;

  // Each stage moves on when the stage after it has room or is moving on too.
  // Cells without vertices leave stage two whether the sequencer is busy or not.
  assign out_ready = !out_v_q || !out_stall_i;
  assign emit      = seq_v_q && out_ready;
  assign seq_last  = (seq_k_q == seq_n_q - CNT_W'(1));
  assign seq_ready = !seq_v_q || (emit && seq_last);
  assign s2_n      = vtx_count(s2_mask_q);
  assign s2_ready  = !s2_v_q || seq_ready || (s2_n == '0);
  assign seq_load  = s2_v_q && seq_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // A corner is wet when its kind bit is set, it has water, and the water is
  // not below the ground. A cell outside the tile is treated as all dry.
  always_comb begin
    s2_mask_d = '0;
    for (int i = 0; i < 4; i++) begin
      s2_mask_d[i] = s1_kind_q[i] && (s1_wz_q[i] != NO_WATER) && (s1_wz_q[i] >= s1_gz_q[i]);
    end
    if (int'(s1_cx_q) >= SIDE_CELLS - 1 || int'(s1_cy_q) >= SIDE_CELLS - 1) begin
      s2_mask_d = '0;
    end
  end

  // The current vertex: position in half cells, then scaled by the step.
  assign seq_list = build_list(seq_mask_q);
  assign seq_vtx  = seq_list.v[seq_k_q];
  assign seq_xs   = {1'b0, seq_cx_q, 1'b0} + 10'(seq_vtx.dx);
  assign seq_ys   = {1'b0, seq_cy_q, 1'b0} + 10'(seq_vtx.dy);
  assign seq_x2   = COORD_W'(seq_xs) * COORD_W'(cell_step_q);
  assign seq_y2   = COORD_W'(seq_ys) * COORD_W'(cell_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_step_q <= 16'd1;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      seq_v_q     <= 1'b0;
      seq_k_q     <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cell_step_q <= cfg_cell_step_i;
      end
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (seq_ready) begin
        seq_v_q <= s2_v_q && (s2_n != '0);
        seq_k_q <= '0;
      end else if (emit) begin
        seq_k_q <= seq_k_q + CNT_W'(1);
      end
      if (out_ready) begin
        out_v_q <= emit;
      end
    end
  end

  // Payload registers load only when their stage takes a new request.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_cx_q    <= cell_x_i;
      s1_cy_q    <= cell_y_i;
      s1_wz_q[0] <= water_z_00_i;
      s1_wz_q[1] <= water_z_10_i;
      s1_wz_q[2] <= water_z_11_i;
      s1_wz_q[3] <= water_z_01_i;
      s1_gz_q[0] <= ground_z_00_i;
      s1_gz_q[1] <= ground_z_10_i;
      s1_gz_q[2] <= ground_z_11_i;
      s1_gz_q[3] <= ground_z_01_i;
      s1_kind_q  <= kind_mask_i;
    end
    if (s2_ready && s1_v_q) begin
      s2_mask_q <= s2_mask_d;
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      for (int i = 0; i < 4; i++) begin
        s2_z_q[i] <= Z_W'(s1_wz_q[i]) + Z_W'(1);
      end
    end
    if (seq_load) begin
      seq_mask_q <= s2_mask_q;
      seq_cx_q   <= s2_cx_q;
      seq_cy_q   <= s2_cy_q;
      seq_n_q    <= s2_n;
      for (int i = 0; i < 4; i++) begin
        seq_z_q[i] <= s2_z_q[i];
      end
    end
    if (emit) begin
      out_x2_q   <= seq_x2;
      out_y2_q   <= seq_y2;
      out_z_q    <= seq_z_q[seq_vtx.zsel];
      out_pend_q <= seq_vtx.poly_end;
      out_last_q <= seq_last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign vertex_x2_o   = out_x2_q;
  assign vertex_y2_o   = out_y2_q;
  assign vertex_z_o    = out_z_q;
  assign polygon_end_o = out_pend_q;
  assign last_o        = out_last_q;

  // The sequencer never works on an empty list and never steps past its end.
  `ASSERT_AT(seq_count_a, clk_i, rst_ni,
             seq_v_q |-> (seq_n_q != '0 && seq_k_q < seq_n_q), "sequencer index out of range")
  // The last vertex of a cell always closes a polygon.
  `ASSERT_NEVER(last_open_a, clk_i, rst_ni,
                out_v_q && out_last_q && !out_pend_q, "cell ended inside a polygon")
  // An empty front stage never holds off a request.
  `ASSERT_NEVER(idle_stall_a, clk_i, rst_ni,
                !s1_v_q && in_stall_o, "stall with empty front stage")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for water_cell_contour_polygonizer_top: a directed table of cells, then
// random cells under several cell_step settings, all checked vertex by vertex.
// Depends on wccp_pkg and the RTL of the block; reads no files.
`default_nettype none

module testbench
  import wccp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;

  // One cell request. Corner index 0..3 stands for corners 00, 10, 11, 01.
  typedef struct packed {
    logic [7:0]       cx;
    logic [7:0]       cy;
    logic [3:0][31:0] wz;
    logic [3:0][31:0] gz;
    logic [3:0]       kind;
  } cell_t;

  typedef struct packed {
    logic [COORD_W-1:0]    x2;
    logic [COORD_W-1:0]    y2;
    logic signed [Z_W-1:0] z;
    logic                  pend;
    logic                  lst;
  } vertex_t;

  // A directed row either has its result typed in (the cell gives no vertex at all)
  // or leaves it to the polygonizer below.
  typedef struct packed {
    cell_t req;
    bit    no_vertices;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [15:0]           cfg_step;
  logic                  in_valid;
  logic                  in_stall;
  cell_t                 cur_cell;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    vx2;
  logic [COORD_W-1:0]    vy2;
  logic signed [Z_W-1:0] vz;
  logic                  vpend;
  logic                  vlast;

  vertex_t   expected_vertices[$];
  stim_row_t directed_rows[$];
  logic [15:0] step_now;
  int        errors;
  int        cycles;
  int        idle_pct;
  bit        hold_out;

  water_cell_contour_polygonizer_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_cell_step_i (cfg_step),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cell_x_i        (cur_cell.cx),
    .cell_y_i        (cur_cell.cy),
    .water_z_00_i    (cur_cell.wz[0]),
    .water_z_10_i    (cur_cell.wz[1]),
    .water_z_11_i    (cur_cell.wz[2]),
    .water_z_01_i    (cur_cell.wz[3]),
    .ground_z_00_i   (cur_cell.gz[0]),
    .ground_z_10_i   (cur_cell.gz[1]),
    .ground_z_11_i   (cur_cell.gz[2]),
    .ground_z_01_i   (cur_cell.gz[3]),
    .kind_mask_i     (cur_cell.kind),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .vertex_x2_o     (vx2),
    .vertex_y2_o     (vy2),
    .vertex_z_o      (vz),
    .polygon_end_o   (vpend),
    .last_o          (vlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // sx and sy are grid positions already doubled (corners) or summed (midpoints).
  function automatic vertex_t place_vertex(logic [9:0] sx, logic [9:0] sy, logic [31:0] w);
    vertex_t v;
    v.x2   = COORD_W'(32'(sx) * 32'(step_now));
    v.y2   = COORD_W'(32'(sy) * 32'(step_now));
    v.z    = {w[31], w} + 33'sd1;
    v.pend = 1'b0;
    v.lst  = 1'b0;
    return v;
  endfunction

  // Marching squares over one cell. Appends the vertices it gives, in fan order,
  // to the queue of expected vertices.
  function automatic void polygonize_cell(cell_t c);
    vertex_t    vs[MAX_VTX];
    int         n;
    int         k;
    int         prv;
    int         nxt;
    bit         open;
    logic [8:0] gx[4];
    logic [8:0] gy[4];
    logic [3:0] wet;
    n = 0;
    if (int'(c.cx) >= SIDE_CELLS - 1 || int'(c.cy) >= SIDE_CELLS - 1) return;
    gx[0] = 9'(c.cx);         gy[0] = 9'(c.cy);
    gx[1] = 9'(c.cx) + 9'd1;  gy[1] = 9'(c.cy);
    gx[2] = 9'(c.cx) + 9'd1;  gy[2] = 9'(c.cy) + 9'd1;
    gx[3] = 9'(c.cx);         gy[3] = 9'(c.cy) + 9'd1;
    for (int i = 0; i < 4; i++) begin
      wet[i] = c.kind[i] && (c.wz[i] != NO_WATER) && ($signed(c.wz[i]) >= $signed(c.gz[i]));
    end
    if (wet == 4'h0) return;
    if (wet == 4'hF) begin
      for (int i = 0; i < 4; i++) begin
        vs[n] = place_vertex({gx[i], 1'b0}, {gy[i], 1'b0}, c.wz[i]);
        n++;
      end
      vs[n-1].pend = 1'b1;
    end else begin
      for (int s = 0; s < 4; s++) begin
        prv = (s + 3) % 4;
        if (wet[s] && !wet[prv]) begin
          // Open on the edge from the dry neighbor, walk the run, close on the next dry edge.
          vs[n] = place_vertex(10'(gx[s]) + 10'(gx[prv]), 10'(gy[s]) + 10'(gy[prv]), c.wz[s]);
          n++;
          k    = s;
          open = 1'b1;
          while (open) begin
            vs[n] = place_vertex({gx[k], 1'b0}, {gy[k], 1'b0}, c.wz[k]);
            n++;
            nxt = (k + 1) % 4;
            if (!wet[nxt]) begin
              vs[n] = place_vertex(10'(gx[k]) + 10'(gx[nxt]), 10'(gy[k]) + 10'(gy[nxt]),
                                   c.wz[k]);
              n++;
              open = 1'b0;
            end
            k = nxt;
          end
          vs[n-1].pend = 1'b1;
        end
      end
    end
    vs[n-1].lst = 1'b1;
    for (int i = 0; i < n; i++) expected_vertices.push_back(vs[i]);
  endfunction

  function automatic cell_t even_cell(logic [7:0] x, logic [7:0] y, logic [3:0] kind,
                                      logic [31:0] w, logic [31:0] g);
    cell_t c;
    c.cx   = x;
    c.cy   = y;
    c.kind = kind;
    for (int i = 0; i < 4; i++) begin
      c.wz[i] = w;
      c.gz[i] = g;
    end
    return c;
  endfunction

  // Heights are picked per corner so that wet and dry corners are both common,
  // with ties, the no-water value and full-range values mixed in.
  function automatic cell_t random_cell();
    cell_t c;
    c.cx = ($urandom_range(0, 9) == 0) ? 8'(254 + $urandom_range(0, 1)) : 8'($urandom);
    c.cy = ($urandom_range(0, 9) == 0) ? 8'(254 + $urandom_range(0, 1)) : 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      c.kind[i] = ($urandom_range(0, 99) < 80);
      case ($urandom_range(0, 7))
        0: begin
          c.wz[i] = NO_WATER;
          c.gz[i] = $urandom_range(0, 1) ? NO_WATER : $urandom;
        end
        1: begin
          c.wz[i] = $urandom;
          c.gz[i] = c.wz[i];
        end
        2, 3: begin
          c.wz[i] = $urandom;
          c.gz[i] = $urandom;
        end
        default: begin
          c.gz[i] = $urandom;
          c.wz[i] = c.gz[i] + $urandom_range(0, 1000);
        end
      endcase
    end
    return c;
  endfunction

  // Every arriving vertex is matched against the oldest expectation.
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex with no expectation: x2=%0d y2=%0d z=%0d", vx2, vy2, vz);
        errors++;
      end else begin
        want = expected_vertices.pop_front();
        if (vx2 !== want.x2) begin
          $error("vertex_x2: expected %0d, got %0d", want.x2, vx2);
          errors++;
        end
        if (vy2 !== want.y2) begin
          $error("vertex_y2: expected %0d, got %0d", want.y2, vy2);
          errors++;
        end
        if (vz !== want.z) begin
          $error("vertex_z: expected %0d, got %0d", want.z, vz);
          errors++;
        end
        if (vpend !== want.pend) begin
          $error("polygon_end: expected %0b, got %0b", want.pend, vpend);
          errors++;
        end
        if (vlast !== want.lst) begin
          $error("last: expected %0b, got %0b", want.lst, vlast);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  // Offers one request, sometimes after a random gap, and returns at the edge that takes it.
  task automatic send_cell(cell_t c, bit no_vertices);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cur_cell <= c;
    do @(posedge clk); while (in_stall);
    if (!no_vertices) polygonize_cell(c);
  endtask

  // Lets every expected vertex arrive, then waits on for cells that give no
  // vertex but may still be in the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_step <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    step_now = v;
  endtask

  initial begin
    logic [15:0] phase_steps[4];
    cell_t       c;
    errors   = 0;
    cycles   = 0;
    idle_pct = 10;
    hold_out = 1'b0;
    step_now = 16'd1;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_step <= '0;
    in_valid <= 1'b0;
    cur_cell <= '0;

    // Cells that give nothing: dry by kind, no-water corners, water below ground,
    // and cells outside the tile.
    directed_rows.push_back('{even_cell(8'd3, 8'd4, 4'h0, 32'd100, 32'd0), 1'b1});
    directed_rows.push_back('{even_cell(8'd3, 8'd4, 4'hF, NO_WATER, NO_WATER), 1'b1});
    directed_rows.push_back('{even_cell(8'd3, 8'd4, 4'hF, 32'd5, 32'd6), 1'b1});
    directed_rows.push_back('{even_cell(8'd255, 8'd0, 4'hF, 32'd100, 32'd0), 1'b1});
    directed_rows.push_back('{even_cell(8'd0, 8'd255, 4'hF, 32'd100, 32'd0), 1'b1});
    directed_rows.push_back('{even_cell(8'd255, 8'd255, 4'hF, 32'd100, 32'd0), 1'b1});
    // Grid corners of the tile and the height extremes.
    directed_rows.push_back('{even_cell(8'd0, 8'd0, 4'hF, 32'd100, 32'd0), 1'b0});
    directed_rows.push_back('{even_cell(8'd254, 8'd254, 4'hF, 32'd100, 32'd0), 1'b0});
    directed_rows.push_back('{even_cell(8'd254, 8'd0, 4'hF, 32'h7FFF_FFFF, NO_WATER), 1'b0});
    directed_rows.push_back('{even_cell(8'd0, 8'd254, 4'hF, 32'h8000_0001, NO_WATER), 1'b0});
    directed_rows.push_back('{even_cell(8'd17, 8'd9, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0});
    // Every other wet pattern: single corners, adjacent pairs, diagonals, three wet.
    foreach (phase_steps[i]) phase_steps[i] = '0;
    for (int m = 1; m < 15; m++) begin
      c = even_cell(8'(m * 11), 8'(200 - m * 7), 4'(m), 32'(m * 1000 - 5000), 32'(-6000));
      directed_rows.push_back('{c, 1'b0});
    end
    // A no-water corner with its kind set stays dry even though it is not below the ground.
    c = even_cell(8'd128, 8'd127, 4'hF, 32'd7, NO_WATER);
    c.wz[2] = NO_WATER;
    directed_rows.push_back('{c, 1'b0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs at the reset value of cell_step.
    foreach (directed_rows[i]) send_cell(directed_rows[i].req, directed_rows[i].no_vertices);

    phase_steps[0] = 16'hFFFF;
    phase_steps[1] = 16'h0000;
    phase_steps[2] = 16'($urandom_range(2, 65534));
    phase_steps[3] = 16'd1;
    for (int p = 0; p < 4; p++) begin
      write_step(phase_steps[p]);
      // Phase two runs without any idling on either side.
      idle_pct = (p == 2) ? 0 : 10;
      // Phase one opens with a long hold-off so that the block backs up into its input.
      if (p == 1) hold_out = 1'b1;
      for (int i = 0; i < 49; i++) begin
        // The sender waits once for the block to empty completely mid-phase.
        if (p == 0 && i == 25) drain();
        send_cell(random_cell(), 1'b0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
